[rtl/assert_macros.svh]
// assertion helpers shared by the voxel hash table modules
// expect i_clk and i_rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks suspended while reset is low
`define VXH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks suspended while reset is low
`define VXH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vxh_pkg.sv]
// shared types, codes and constants of the voxel hash table
// no dependencies
`default_nettype none

package vxh_pkg;

    localparam int COORD_W  = 10;
    localparam int COLOR_W  = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 12;
    localparam int COUNT_W  = 13;
    localparam int CFG_W    = 4;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int COORD_BITS_DEF  = 10;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RST = 4'd12;
    localparam int               SIZE_LOG2_MIN = 3;

    // register indexes (byte address / 4)
    localparam logic [PADDR_W-3:0] REG_SIZE_LOG2 = '0;

    // hash constants, 32-bit fractions of 0.618033988 and 0.707106781
    localparam logic [31:0] HASH_A   = 32'h9E3779B6;
    localparam logic [31:0] HASH_B   = 32'hB504F333;
    // 5381 * 33^3, the seed folded through all three rounds
    localparam logic [31:0] KEY_BASE = 32'd193376997;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [COLOR_W-1:0]  t_color;
    typedef logic [COORD_W-1:0]  t_coord;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_FOUND     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic hash_a;
        logic hash_b;
        logic rd;
        logic chk;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic probe_end;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/vxh_in_if.sv]
// input item channel of the voxel hash table
// depends on vxh_pkg
`default_nettype none

interface vxh_in_if;
    import vxh_pkg::*;

    logic   valid;
    logic   ready;
    logic   command;
    t_coord voxel_x;
    t_coord voxel_y;
    t_coord voxel_z;
    t_color red;
    t_color green;
    t_color blue;

    modport source (output valid, command, voxel_x, voxel_y, voxel_z, red, green, blue,
                    input ready);
    modport sink (input valid, command, voxel_x, voxel_y, voxel_z, red, green, blue,
                  output ready);
endinterface

`default_nettype wire

[rtl/vxh_out_if.sv]
// result item channel of the voxel hash table
// depends on vxh_pkg
`default_nettype none

interface vxh_out_if;
    import vxh_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, slot, entry_count, input ready);
    modport sink (input valid, status, slot, entry_count, output ready);
endinterface

`default_nettype wire

[rtl/vxh_ctrl.sv]
// sequencer of the voxel hash table: clearing pass, hashing, probe loop
// depends on vxh_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module vxh_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire vxh_pkg::t_dp_stat i_stat,
    output vxh_pkg::t_dp_cmd       o_cmd
);
    import vxh_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH_A = 3'd2;
    localparam logic [2:0] S_HASH_B = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH_A;
                end
            end
            S_HASH_A: begin
                o_cmd.hash_a = 1'b1;
                n_state      = S_HASH_B;
            end
            S_HASH_B: begin
                o_cmd.hash_b = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_stat.probe_end ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    `VXH_ASSERT_NEXT(a_accept_to_hash, i_in_valid && o_in_ready, r_state == S_HASH_A, "accepted item did not start hashing")
    `VXH_ASSERT_IMPL(a_out_load_free, o_cmd.out_load, i_stat.out_free, "result loaded over a pending one")
    `VXH_ASSERT_NEXT(a_probe_loop, (r_state == S_CHECK) && !i_stat.probe_end, r_state == S_READ, "unfinished probe did not continue")

endmodule

`default_nettype wire

[rtl/vxh_datapath.sv]
// slot memory, hash unit, probe registers and result register
// depends on vxh_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module vxh_datapath #(
    parameter int TABLE_DEPTH = vxh_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = vxh_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire vxh_pkg::t_dp_cmd        i_cmd,
    output vxh_pkg::t_dp_stat            o_stat,
    input  wire [vxh_pkg::CFG_W-1:0]     i_size_log2,
    input  wire                          i_command,
    input  wire [vxh_pkg::COORD_W-1:0]   i_voxel_x,
    input  wire [vxh_pkg::COORD_W-1:0]   i_voxel_y,
    input  wire [vxh_pkg::COORD_W-1:0]   i_voxel_z,
    input  wire [vxh_pkg::COLOR_W-1:0]   i_red,
    input  wire [vxh_pkg::COLOR_W-1:0]   i_green,
    input  wire [vxh_pkg::COLOR_W-1:0]   i_blue,
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output logic [vxh_pkg::STATUS_W-1:0] o_out_status,
    output logic [vxh_pkg::SLOT_W-1:0]   o_out_slot,
    output logic [vxh_pkg::COUNT_W-1:0]  o_out_count
);
    import vxh_pkg::*;

    localparam int IW       = $clog2(TABLE_DEPTH);
    localparam int MAX_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int CW       = MAX_LOG2 + 1;
    localparam int CRD_W    = 3 * COORD_BITS;
    localparam int COL_W    = 3 * COLOR_W;
    localparam int DW       = 1 + COL_W + CRD_W;

    // item registers
    logic                r_cmd;
    logic [CRD_W-1:0]    r_coords;
    logic [COL_W-1:0]    r_color;
    logic [31:0]         r_key;

    // probe registers
    logic [IW-1:0]       r_slot;
    logic [IW-1:0]       r_step;
    logic [CW-1:0]       r_cnt;
    logic [DW-1:0]       r_rd_data;
    logic [DW-1:0]       r_mem [0:TABLE_DEPTH-1];
    logic [IW-1:0]       r_clr_addr;

    // result
    logic [COUNT_W-1:0]  r_count;
    t_status             r_res_status;
    logic [IW-1:0]       r_res_slot;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [COUNT_W-1:0]  r_out_count;

    logic [COORD_BITS-1:0] w_xm;
    logic [COORD_BITS-1:0] w_ym;
    logic [COORD_BITS-1:0] w_zm;
    logic [31:0]         w_key;
    logic [4:0]          w_s;
    logic [CW-1:0]       w_size;
    logic [IW-1:0]       w_mask;
    logic [31:0]         w_mconst;
    logic [31:0]         w_prod;
    logic [5:0]          w_shamt;
    logic [31:0]         w_hash;
    logic                w_rd_valid;
    logic                w_match;
    logic                w_last;
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic [DW-1:0]       w_wdata;

    assign w_xm = i_voxel_x[COORD_BITS-1:0];
    assign w_ym = i_voxel_y[COORD_BITS-1:0];
    assign w_zm = i_voxel_z[COORD_BITS-1:0];

    // k = 5381*33^3 + x*33^2 + y*33 + z, as shifts and adds
    assign w_key = KEY_BASE + (32'(w_xm) << 10) + (32'(w_xm) << 6) + 32'(w_xm)
                 + (32'(w_ym) << 5) + 32'(w_ym) + 32'(w_zm);

    // active size saturated to the supported range
    always_comb begin
        if (i_size_log2 < CFG_W'(SIZE_LOG2_MIN)) begin
            w_s = 5'(SIZE_LOG2_MIN);
        end else if ({1'b0, i_size_log2} > 5'(MAX_LOG2)) begin
            w_s = 5'(MAX_LOG2);
        end else begin
            w_s = {1'b0, i_size_log2};
        end
    end

    assign w_size = CW'(1) << w_s;
    assign w_mask = IW'(w_size - CW'(1));

    // one multiplier shared by both hashes, top s bits of the low word
    assign w_mconst = i_cmd.hash_b ? HASH_B : HASH_A;
    assign w_prod   = r_key * w_mconst;
    assign w_shamt  = 6'd32 - {1'b0, w_s};
    assign w_hash   = w_prod >> w_shamt;

    assign w_rd_valid = r_rd_data[DW-1];
    assign w_match    = (r_rd_data[CRD_W-1:0] == r_coords);
    assign w_last     = ((r_cnt + CW'(1)) == w_size);

    assign o_stat.clr_last  = (r_clr_addr == IW'(TABLE_DEPTH - 1));
    assign o_stat.probe_end = !w_rd_valid || w_match || w_last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_command;
            r_coords <= {w_zm, w_ym, w_xm};
            r_color  <= {i_blue, i_green, i_red};
            r_key    <= w_key;
        end
    end

    // probe walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_a) begin
            r_slot <= IW'(w_hash);
            r_cnt  <= '0;
        end else if (i_cmd.hash_b) begin
            r_step <= IW'(w_hash) | IW'(1);
        end else if (i_cmd.chk) begin
            if (!w_rd_valid) begin
                r_res_status <= (r_cmd == CMD_INSERT) ? ST_INSERTED : ST_NOT_FOUND;
                r_res_slot   <= (r_cmd == CMD_INSERT) ? r_slot : '0;
            end else if (w_match) begin
                r_res_status <= (r_cmd == CMD_INSERT) ? ST_DUPLICATE : ST_FOUND;
                r_res_slot   <= r_slot;
            end else begin
                r_slot <= (r_slot + r_step) & w_mask;
                r_cnt  <= r_cnt + CW'(1);
                if (w_last) begin
                    r_res_status <= (r_cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    r_res_slot   <= '0;
                end
            end
        end
    end

    // single write port shared by the clearing pass and inserts
    assign w_we    = i_cmd.clr_wr || (i_cmd.chk && !w_rd_valid && (r_cmd == CMD_INSERT));
    assign w_waddr = i_cmd.clr_wr ? r_clr_addr : r_slot;
    assign w_wdata = i_cmd.clr_wr ? '0 : {1'b1, r_color, r_coords};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_count    <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
            if (i_cmd.chk && !w_rd_valid && (r_cmd == CMD_INSERT)) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= SLOT_W'(r_res_slot);
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;
    assign o_out_count  = r_out_count;

    `VXH_ASSERT_NEXT(a_count_only_on_check, !i_cmd.chk, $stable(r_count), "entry count moved outside a probe check")
    `VXH_ASSERT_IMPL(a_slot_in_range, i_cmd.chk, (r_slot & ~w_mask) == '0, "probe slot outside active table")
    `VXH_ASSERT_NEXT(a_match_slot, i_cmd.chk && w_rd_valid && w_match, r_res_slot == $past(r_slot), "match reported at wrong slot")

endmodule

`default_nettype wire

[rtl/voxel_hash_table_double_hashing_core.sv]
// voxel hash table with double hashing: top level, config register, wiring
// depends on vxh_pkg, vxh_in_if, vxh_out_if, vxh_ctrl, vxh_datapath
// flow: an accepted item goes through hash A, hash B, a read/check pair per probe
//   (p = probes, 1..2^s), then done, where it waits for a free result register;
//   no new item is taken until its result is loaded (slot memory read registered)
// reset: synchronous active low; after release a clearing pass writes every slot
//   invalid, during which no item is taken (config still is)
`default_nettype none

module voxel_hash_table_double_hashing_core #(
    parameter int TABLE_DEPTH = vxh_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = vxh_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    vxh_in_if.sink                       i_item,
    vxh_out_if.source                    o_result,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [vxh_pkg::PADDR_W-1:0]   paddr,
    input  wire [vxh_pkg::PDATA_W-1:0]   pwdata,
    output logic [vxh_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import vxh_pkg::*;

    // size_log2 register, reset to the full table
    logic [CFG_W-1:0] r_size_log2;
    logic             w_reg_hit;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    // register select ignores the byte lane bits
    assign w_reg_hit = (paddr[PADDR_W-1:2] == REG_SIZE_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_LOG2_RST;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_size_log2 <= pwdata[CFG_W-1:0];
        end
    end

    // zero-wait port, reads of unused addresses give zero
    assign pready = 1'b1;
    assign prdata = w_reg_hit ? PDATA_W'(r_size_log2) : '0;

    // controller: clearing pass, then accept / hash / probe / deliver
    vxh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_item.ready = w_in_ready;

    // datapath: slot memory, shared hash multiplier, result register
    vxh_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_size_log2  (r_size_log2),
        .i_command    (i_item.command),
        .i_voxel_x    (i_item.voxel_x),
        .i_voxel_y    (i_item.voxel_y),
        .i_voxel_z    (i_item.voxel_z),
        .i_red        (i_item.red),
        .i_green      (i_item.green),
        .i_blue       (i_item.blue),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (o_result.valid),
        .o_out_status (o_result.status),
        .o_out_slot   (o_result.slot),
        .o_out_count  (o_result.entry_count)
    );

endmodule

`default_nettype wire
